// ----- hw/rtl/gww_pkg.sv -----
// Shared types and constants for the greedy word-wrap line breaker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gww_pkg;

   // item kind codes
   localparam logic [1:0] KIND_SPACE   = 2'd1;
   localparam logic [1:0] KIND_NEWLINE = 2'd2;

   localparam int KIND_BITS        = 2;
   localparam int GLYPH_BITS       = 8;
   localparam int OUT_POS_BITS     = 16;
   localparam int LINE_WIDTH_BITS  = 20;
   localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 20'd320;

   localparam int POSITION_BITS_DEF = 16;
   localparam int WIDTH_BITS_DEF    = 20;

   typedef struct packed {
      logic [KIND_BITS-1:0]  item_kind;
      logic [GLYPH_BITS-1:0] glyph_px;
      logic [GLYPH_BITS-1:0] glyph_spacing;
      logic                  last_of_text;
   } item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gww_req_if.sv -----
// Glyph item channel of the word-wrap block: valid/ready plus item fields.
// Depends on gww_pkg for field widths.
`default_nettype none

interface gww_req_if;
   import gww_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  item_kind;
   logic [GLYPH_BITS-1:0] glyph_px;
   logic [GLYPH_BITS-1:0] glyph_spacing;
   logic                  last_of_text;

   modport source (output valid, item_kind, glyph_px, glyph_spacing, last_of_text,
                   input ready);
   modport sink   (input valid, item_kind, glyph_px, glyph_spacing, last_of_text,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gww_rsp_if.sv -----
// Break result channel of the word-wrap block: valid/ready plus result fields.
// Depends on gww_pkg for field widths.
`default_nettype none

interface gww_rsp_if;
   import gww_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    break_earlier;
   logic [OUT_POS_BITS-1:0] earlier_position;
   logic                    break_here;
   logic [OUT_POS_BITS-1:0] item_position;

   modport source (output valid, break_earlier, earlier_position, break_here, item_position,
                   input ready);
   modport sink   (input valid, break_earlier, earlier_position, break_here, item_position,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gww_in_reg.sv -----
// Input register stage: captures one glyph item per transfer.
// Depends on gww_pkg and gww_req_if.
`default_nettype none

module gww_in_reg (
   input  wire logic         clock,
   input  wire logic         reset,
   gww_req_if.sink           req_chan,
   input  wire logic         core_ready,
   output gww_pkg::item_type item,
   output logic              item_valid
);
   import gww_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_chan.ready = !valid_ff || core_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (core_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.item_kind     <= req_chan.item_kind;
         item_ff.glyph_px      <= req_chan.glyph_px;
         item_ff.glyph_spacing <= req_chan.glyph_spacing;
         item_ff.last_of_text  <= req_chan.last_of_text;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gww_core.sv -----
// Line-breaking state, per-item decision logic and the result register.
// Depends on gww_pkg and gww_rsp_if.
`default_nettype none

module gww_core #(
   parameter int POSITION_BITS = gww_pkg::POSITION_BITS_DEF,
   parameter int WIDTH_BITS    = gww_pkg::WIDTH_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [gww_pkg::LINE_WIDTH_BITS-1:0] csr_wr_data,
   input  wire gww_pkg::item_type                   item,
   input  wire logic                                item_valid,
   output logic                                     core_ready,
   gww_rsp_if.source                                rsp_chan
);
   import gww_pkg::*;

   localparam int P  = POSITION_BITS;
   localparam int W  = WIDTH_BITS;
   // compare width: holds every exact sum and the line width register
   localparam int CB = (W + 2 > LINE_WIDTH_BITS + 1) ? W + 2 : LINE_WIDTH_BITS + 1;
   // position width before truncation to the output field
   localparam int XB = (P > OUT_POS_BITS) ? P + 1 : OUT_POS_BITS + 1;
   localparam logic [P-1:0]  POS_ONE  = P'(1);
   localparam logic [P-1:0]  CNT_MAX  = {P{1'b1}};
   localparam logic [CB-1:0] WMAX_EXT = {{(CB-W){1'b0}}, {W{1'b1}}};

   function automatic logic [W-1:0] sat_width(input logic [CB-1:0] v);
      return (v > WMAX_EXT) ? {W{1'b1}} : v[W-1:0];
   endfunction

   // state
   logic [LINE_WIDTH_BITS-1:0] csr_line_width_ff;
   logic [P-1:0]          pos_ff, pos_in;
   logic [P-1:0]          cnt_ff, cnt_in;
   logic [W-1:0]          word_ff, word_in;
   logic [W-1:0]          line_ff, line_in;
   logic [GLYPH_BITS-1:0] lead_ff, lead_in;
   logic [GLYPH_BITS-1:0] prev_sp_ff, prev_sp_in;
   logic                  prev_valid_ff, prev_valid_in;
   logic                  allowed_ff, allowed_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    brk_early_ff, brk_early_in;
   logic                    brk_here_ff, brk_here_in;
   logic [OUT_POS_BITS-1:0] early_pos_ff, early_pos_in;
   logic [OUT_POS_BITS-1:0] item_pos_ff, item_pos_in;

   logic                  advance;
   logic [CB-1:0]         gw_ext, app_ext, lw_ext, fits_sum, line_sum;
   logic [GLYPH_BITS-1:0] app;
   logic                  over_word;
   logic [P-1:0]          earlier, cnt_inc;
   logic [XB-1:0]         earlier_x, pos_x;

   assign core_ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance    = item_valid && core_ready;

   always_comb begin
      gw_ext    = {{(CB-GLYPH_BITS){1'b0}}, item.glyph_px};
      lw_ext    = {{(CB-LINE_WIDTH_BITS){1'b0}}, csr_line_width_ff};
      fits_sum  = {{(CB-W){1'b0}}, line_ff} + {{(CB-GLYPH_BITS){1'b0}}, lead_ff}
                + {{(CB-W){1'b0}}, word_ff};
      over_word = fits_sum > lw_ext;
      earlier   = pos_ff - cnt_ff - POS_ONE;
      earlier_x = {{(XB-P){1'b0}}, earlier};
      pos_x     = {{(XB-P){1'b0}}, pos_ff};
      // first glyph of a line carries no leading spacing
      if (prev_valid_ff) begin
         app = (item.glyph_spacing > prev_sp_ff) ? item.glyph_spacing : prev_sp_ff;
      end else begin
         app = '0;
      end
      app_ext = {{(CB-GLYPH_BITS){1'b0}}, app};
      cnt_inc = (cnt_ff != CNT_MAX) ? cnt_ff + POS_ONE : cnt_ff;

      cnt_in        = cnt_ff;
      word_in       = word_ff;
      line_in       = line_ff;
      lead_in       = lead_ff;
      prev_sp_in    = prev_sp_ff;
      prev_valid_in = prev_valid_ff;
      allowed_in    = allowed_ff;
      brk_early_in  = 1'b0;
      brk_here_in   = 1'b0;
      line_sum      = '0;

      case (item.item_kind)
         KIND_NEWLINE: begin
            brk_early_in  = allowed_ff && (cnt_ff != '0) && over_word;
            cnt_in        = '0;
            word_in       = '0;
            line_in       = '0;
            prev_valid_in = 1'b0;
            prev_sp_in    = '0;
            allowed_in    = 1'b0;
         end
         KIND_SPACE: begin
            if (cnt_ff != '0) begin
               if (allowed_ff && over_word) begin
                  // word moves to a new line: line restarts with the word and this space
                  brk_early_in = 1'b1;
                  line_sum     = {{(CB-W){1'b0}}, word_ff} + app_ext + gw_ext;
               end else begin
                  line_sum = fits_sum + app_ext + gw_ext;
               end
               cnt_in  = '0;
               word_in = '0;
            end else begin
               line_sum = {{(CB-W){1'b0}}, line_ff} + app_ext + gw_ext;
            end
            if (line_sum > lw_ext) begin
               line_in       = '0;
               prev_valid_in = 1'b0;
               prev_sp_in    = '0;
               allowed_in    = 1'b0;
               brk_here_in   = 1'b1;
            end else begin
               line_in       = sat_width(line_sum);
               prev_valid_in = 1'b1;
               prev_sp_in    = item.glyph_spacing;
               allowed_in    = 1'b1;
            end
         end
         default: begin
            // ordinary glyph, and the unused code treated likewise
            cnt_in = cnt_inc;
            if (cnt_inc == POS_ONE) begin
               lead_in = app;
               word_in = {{(W-GLYPH_BITS){1'b0}}, item.glyph_px};
            end else begin
               word_in = sat_width({{(CB-W){1'b0}}, word_ff} + app_ext + gw_ext);
            end
            prev_valid_in = 1'b1;
            prev_sp_in    = item.glyph_spacing;
         end
      endcase

      early_pos_in = brk_early_in ? earlier_x[OUT_POS_BITS-1:0] : '0;
      item_pos_in  = pos_x[OUT_POS_BITS-1:0];

      if (item.last_of_text) begin
         pos_in        = '0;
         cnt_in        = '0;
         word_in       = '0;
         line_in       = '0;
         lead_in       = '0;
         prev_sp_in    = '0;
         prev_valid_in = 1'b0;
         allowed_in    = 1'b0;
      end else begin
         pos_in = pos_ff + POS_ONE;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         csr_line_width_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         cnt_ff        <= '0;
         word_ff       <= '0;
         line_ff       <= '0;
         lead_ff       <= '0;
         prev_sp_ff    <= '0;
         prev_valid_ff <= 1'b0;
         allowed_ff    <= 1'b0;
      end else if (advance) begin
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         word_ff       <= word_in;
         line_ff       <= line_in;
         lead_ff       <= lead_in;
         prev_sp_ff    <= prev_sp_in;
         prev_valid_ff <= prev_valid_in;
         allowed_ff    <= allowed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         brk_early_ff <= brk_early_in;
         early_pos_ff <= early_pos_in;
         brk_here_ff  <= brk_here_in;
         item_pos_ff  <= item_pos_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.break_earlier    = brk_early_ff;
   assign rsp_chan.earlier_position = early_pos_ff;
   assign rsp_chan.break_here       = brk_here_ff;
   assign rsp_chan.item_position    = item_pos_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_word_wrap.sv -----
// Greedy word-wrap line breaker, top level.
// Depends on gww_pkg, gww_req_if, gww_rsp_if, gww_in_reg and gww_core.
//
// Usage:
//   req_chan carries glyph items (kind, width, font spacing, last flag);
//   rsp_chan returns exactly one result per item, in order: whether the
//   space before the current word and/or this space become line breaks,
//   with their stream positions. csr_wr_en/csr_wr_data write the line
//   width; write it only while no item is in flight.
//   A result passes the input register, then the result register after
//   one pass of adders and comparators over the running line and word
//   widths. Throughput: one item per cycle while the receiver does not
//   stall; the running sums are combinational, so consecutive items
//   need no gap. Reset clears the running line state and both valid
//   registers and sets the line width to 320. When the receiver stalls,
//   the result register holds, the input register takes one more item
//   if it is empty, and then req_chan.ready drops until the result is
//   taken.
`default_nettype none

module greedy_word_wrap #(
   parameter int POSITION_BITS = gww_pkg::POSITION_BITS_DEF,
   parameter int WIDTH_BITS    = gww_pkg::WIDTH_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   gww_req_if.sink                                  req_chan,
   gww_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [gww_pkg::LINE_WIDTH_BITS-1:0] csr_wr_data
);
   import gww_pkg::*;

   item_type item;
   logic     item_valid;
   logic     core_ready;

   gww_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .core_ready (core_ready),
      .item       (item),
      .item_valid (item_valid)
   );

   gww_core #(
      .POSITION_BITS (POSITION_BITS),
      .WIDTH_BITS    (WIDTH_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .item_valid  (item_valid),
      .core_ready  (core_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/gww_checker.sv -----
// Port-level checks for the word-wrap block, attached to the top level by bind.
// Depends on gww_pkg for field widths.
`default_nettype none

module gww_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_break_earlier,
   input wire logic [gww_pkg::OUT_POS_BITS-1:0]   rsp_earlier_position,
   input wire logic                               rsp_break_here,
   input wire logic [gww_pkg::OUT_POS_BITS-1:0]   rsp_item_position
);
   import gww_pkg::*;

   // the block comes out of reset with nothing to deliver
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register always lets the input side move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // no earlier break means a zero earlier position
   a_early_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_break_earlier |-> rsp_earlier_position == '0)
      else $error("earlier position set without a break");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_position)
         && $stable(rsp_break_here) && $stable(rsp_break_earlier)
         && $stable(rsp_earlier_position))
      else $error("stalled result changed");

   // a new transfer with no result pending is answered via the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("result missing two cycles after transfer");

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_break_earlier    (rsp_chan.break_earlier),
   .rsp_earlier_position (rsp_chan.earlier_position),
   .rsp_break_here       (rsp_chan.break_here),
   .rsp_item_position    (rsp_chan.item_position)
);

`default_nettype wire

// ----- test/greedy_word_wrap_test.sv -----
// Self-checking bench for greedy_word_wrap: a directed table, random text streams and one
// long word, checked against an in-bench line breaker model or typed table results.
// Depends on gww_pkg, gww_req_if, gww_rsp_if and the greedy_word_wrap RTL.

module greedy_word_wrap_test;
   import gww_pkg::*;

   localparam logic [1:0] KIND_GLYPH  = 2'd0;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [LINE_WIDTH_BITS-1:0] WIDTH_FULL = '1;
   localparam int CYCLE_LIMIT = 400_000;

   typedef struct packed {
      logic                    brk_early;
      logic [OUT_POS_BITS-1:0] early_pos;
      logic                    brk_here;
      logic [OUT_POS_BITS-1:0] item_pos;
   } break_result_type;

   typedef struct packed {
      item_type         it;
      logic             typed;
      break_result_type res;
   } dir_row_type;

   // typed rows carry their result; the rest rely on the model below
   localparam dir_row_type DIRECTED_ROWS [0:21] = '{
      '{'{KIND_GLYPH,   8'd0,   8'd0,   1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_GLYPH,   8'd255, 8'd255, 1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd1}},
      '{'{KIND_SPACE,   8'd0,   8'd0,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_GLYPH,   8'd10,  8'd2,   1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd3}},
      '{'{KIND_UNUSED,  8'd10,  8'd2,   1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd4}},
      '{'{KIND_SPACE,   8'd5,   8'd2,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_GLYPH,   8'd200, 8'd0,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_GLYPH,   8'd100, 8'd0,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_SPACE,   8'd4,   8'd1,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_NEWLINE, 8'd0,   8'd0,   1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd9}},
      '{'{KIND_NEWLINE, 8'd255, 8'd255, 1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd10}},
      '{'{KIND_GLYPH,   8'd255, 8'd0,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_SPACE,   8'd0,   8'd255, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_GLYPH,   8'd255, 8'd255, 1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_NEWLINE, 8'd0,   8'd0,   1'b0}, 1'b0, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_GLYPH,   8'd1,   8'd1,   1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd15}},
      '{'{KIND_SPACE,   8'd255, 8'd255, 1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_SPACE,   8'd255, 8'd255, 1'b0}, 1'b1, '{1'b0, 16'd0, 1'b1, 16'd1}},
      '{'{KIND_GLYPH,   8'd3,   8'd3,   1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd2}},
      '{'{KIND_UNUSED,  8'd255, 8'd0,   1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd3}},
      '{'{KIND_NEWLINE, 8'd0,   8'd0,   1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}},
      '{'{KIND_SPACE,   8'd0,   8'd0,   1'b1}, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_wr_en;
   logic [LINE_WIDTH_BITS-1:0] csr_wr_data;

   gww_req_if req_bus ();
   gww_rsp_if rsp_bus ();

   greedy_word_wrap u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // line breaker model state
   logic [LINE_WIDTH_BITS-1:0] line_limit = LINE_WIDTH_RESET;
   logic [15:0] pos_count;
   logic [15:0] word_count;
   logic [19:0] word_w;
   logic [19:0] line_w;
   logic [7:0]  lead_sp;
   logic [7:0]  prev_sp;
   logic        prev_ok;
   logic        may_break;

   break_result_type expected_breaks [$];

   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   bit long_hold = 1'b0;
   int items_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int early_breaks = 0;
   int here_breaks = 0;
   int widths_used = 1;
   int cycles = 0;

   function automatic logic [19:0] clamp_width(logic [63:0] v);
      return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
   endfunction

   function automatic void clear_line_state();
      pos_count = '0;
      word_count = '0;
      word_w = '0;
      line_w = '0;
      lead_sp = '0;
      prev_sp = '0;
      prev_ok = 1'b0;
      may_break = 1'b0;
   endfunction

   function automatic break_result_type wrap_step(item_type it);
      logic [63:0] fit_sum;
      logic [63:0] line_sum;
      logic [63:0] gap_sp;
      logic [15:0] earlier;
      break_result_type r;
      r = '0;
      r.item_pos = pos_count;
      fit_sum = 64'(line_w) + 64'(lead_sp) + 64'(word_w);
      earlier = pos_count - word_count - 16'd1;
      if (it.item_kind == KIND_NEWLINE) begin
         if (may_break && word_count != 0 && fit_sum > 64'(line_limit)) begin
            r.brk_early = 1'b1;
            r.early_pos = earlier;
         end
         word_count = '0;
         word_w = '0;
         line_w = '0;
         prev_ok = 1'b0;
         prev_sp = '0;
         may_break = 1'b0;
      end else begin
         gap_sp = '0;
         if (prev_ok)
            gap_sp = (it.glyph_spacing > prev_sp) ? 64'(it.glyph_spacing) : 64'(prev_sp);
         if (it.item_kind == KIND_SPACE) begin
            if (word_count != 0) begin
               // the word no longer fits: it opens the next line
               if (may_break && fit_sum > 64'(line_limit)) begin
                  r.brk_early = 1'b1;
                  r.early_pos = earlier;
                  line_sum = 64'(word_w) + gap_sp + 64'(it.glyph_px);
               end else begin
                  line_sum = fit_sum + gap_sp + 64'(it.glyph_px);
               end
               word_count = '0;
               word_w = '0;
            end else begin
               line_sum = 64'(line_w) + gap_sp + 64'(it.glyph_px);
            end
            if (line_sum > 64'(line_limit)) begin
               line_w = '0;
               prev_ok = 1'b0;
               prev_sp = '0;
               may_break = 1'b0;
               r.brk_here = 1'b1;
            end else begin
               line_w = clamp_width(line_sum);
               prev_ok = 1'b1;
               prev_sp = it.glyph_spacing;
               may_break = 1'b1;
            end
         end else begin
            if (word_count != 16'hFFFF)
               word_count = word_count + 16'd1;
            if (word_count == 16'd1) begin
               lead_sp = gap_sp[7:0];
               word_w = 20'(it.glyph_px);
            end else begin
               word_w = clamp_width(64'(word_w) + gap_sp + 64'(it.glyph_px));
            end
            prev_ok = 1'b1;
            prev_sp = it.glyph_spacing;
         end
      end
      if (it.last_of_text)
         clear_line_state();
      else
         pos_count = pos_count + 16'd1;
      return r;
   endfunction

   task automatic feed_item(input item_type it, input bit typed = 1'b0,
                            input break_result_type typed_r = '0);
      int gap;
      break_result_type r;
      gap = req_idle ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.item_kind <= it.item_kind;
      req_bus.glyph_px <= it.glyph_px;
      req_bus.glyph_spacing <= it.glyph_spacing;
      req_bus.last_of_text <= it.last_of_text;
      do @(posedge clock); while (!req_bus.ready);
      r = wrap_step(it);
      expected_breaks.push_back(typed ? typed_r : r);
      items_sent++;
   endtask

   function automatic item_type random_item();
      item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 58)
         it.item_kind = KIND_GLYPH;
      else if (pick < 62)
         it.item_kind = KIND_UNUSED;
      else if (pick < 92)
         it.item_kind = KIND_SPACE;
      else
         it.item_kind = KIND_NEWLINE;
      it.glyph_px = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 48));
      it.glyph_spacing = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 6));
      it.last_of_text = ($urandom_range(0, 31) == 0);
      return it;
   endfunction

   task automatic run_text(input int count);
      repeat (count) feed_item(random_item());
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_breaks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_line_limit(input logic [LINE_WIDTH_BITS-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      line_limit = value;
      widths_used++;
   endtask

   task automatic check_result(input break_result_type got);
      break_result_type want;
      if (expected_breaks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result at position %0d arrived with nothing outstanding", got.item_pos);
      end else begin
         want = expected_breaks.pop_front();
         if (got.brk_early !== want.brk_early || got.early_pos !== want.early_pos ||
             got.brk_here !== want.brk_here || got.item_pos !== want.item_pos) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected early %0b@%0d here %0b pos %0d, got %0b@%0d %0b %0d",
                        want.brk_early, want.early_pos, want.brk_here, want.item_pos,
                        got.brk_early, got.early_pos, got.brk_here, got.item_pos);
         end
      end
      results_checked++;
      early_breaks += got.brk_early;
      here_breaks += got.brk_here;
   endtask

   // result side: random stalls, with one long hold-off on request
   initial begin
      int stall;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            stall = 80;
            long_hold = 1'b0;
         end else begin
            stall = rsp_idle ? $urandom_range(0, 17) : 0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         check_result('{rsp_bus.break_earlier, rsp_bus.earlier_position,
                        rsp_bus.break_here, rsp_bus.item_position});
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.item_kind = KIND_GLYPH;
      req_bus.glyph_px = '0;
      req_bus.glyph_spacing = '0;
      req_bus.last_of_text = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      clear_line_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i])
         feed_item(DIRECTED_ROWS[i].it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      drain();

      set_line_limit('0);
      run_text(100);
      drain();

      set_line_limit(WIDTH_FULL);
      run_text(100);
      drain();

      // back-to-back items while the result side holds off: the block must fill and stall
      set_line_limit(20'($urandom_range(30, 600)));
      req_idle = 1'b0;
      long_hold = 1'b1;
      run_text(150);
      req_idle = 1'b1;
      drain();

      set_line_limit(20'($urandom_range(100, 2000)));
      rsp_idle = 1'b0;
      run_text(150);
      rsp_idle = 1'b1;
      drain();

      // one long word of wide glyphs: it moves to a new line and overflows that one as well
      set_line_limit(20'd2000);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      feed_item('{KIND_GLYPH, 8'd1, 8'd1, 1'b0});
      feed_item('{KIND_SPACE, 8'd10, 8'd1, 1'b0});
      repeat (30)
         feed_item('{($urandom_range(0, 7) == 0) ? KIND_UNUSED : KIND_GLYPH,
                     8'($urandom_range(128, 255)), 8'($urandom_range(0, 255)), 1'b0});
      feed_item('{KIND_SPACE, 8'd0, 8'd0, 1'b0});
      feed_item('{KIND_NEWLINE, 8'd0, 8'd0, 1'b1});
      drain();

      $display("covered %0d glyph items over %0d line widths, %0d results checked",
               items_sent, widths_used, results_checked);
      $display("breaks seen: %0d before a word, %0d at a space; %0d mismatches",
               early_breaks, here_breaks, mismatches);
      if (mismatches == 0 && expected_breaks.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/gww_pkg.sv
hw/rtl/gww_req_if.sv
hw/rtl/gww_rsp_if.sv
hw/rtl/gww_in_reg.sv
hw/rtl/gww_core.sv
hw/rtl/greedy_word_wrap.sv
hw/rtl/gww_checker.sv
test/greedy_word_wrap_test.sv
